// ===== sv/level_meter_peak_hold_smoother_defines.svh =====
// Assertion macros shared by the checker.
`ifndef LEVEL_METER_PEAK_HOLD_SMOOTHER_DEFINES_SVH
`define LEVEL_METER_PEAK_HOLD_SMOOTHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMPHS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmphs: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LMPHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmphs: next-cycle check failed");

`endif

// ===== sv/lmphs_pkg.sv =====
`timescale 1ns / 1ps
package lmphs_pkg;

	localparam int LEVEL_W   = 17;
	localparam int STAMP_W   = 32;
	localparam int COEF_W    = 16;
	localparam int DB_W      = 9;
	localparam int HOLD_W    = 16;
	localparam int RATE_W    = 10;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 40;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// floor(x / 1000) == (x * DIV1000_RECIP) >> DIV1000_SHIFT, exact for x < 2^19,
	// never low above that
	localparam int DIV1000_SHIFT = 29;
	localparam int RATE_SCALED_W = 30;
	localparam logic [19:0] DIV1000_RECIP = 20'd536871;

	localparam logic signed [17:0] OFFSET_Q8 = 18'sd3584;

	localparam logic signed [DB_W-1:0] RST_FLOOR = -9'sd121;
	localparam logic signed [DB_W-1:0] RST_CEIL  = -9'sd33;
	localparam logic [HOLD_W-1:0]      RST_HOLD  = 16'd1500;
	localparam logic [RATE_W-1:0]      RST_RATE  = 10'd20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ATTEN  = 3'd0,
		REG_PREAMP = 3'd1,
		REG_FLOOR  = 3'd2,
		REG_CEIL   = 3'd3,
		REG_HOLD   = 3'd4,
		REG_RATE   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                     atten_on;
		logic                     preamp_on;
		logic signed [DB_W-1:0]   floor_db;
		logic signed [DB_W-1:0]   ceiling_db;
		logic [HOLD_W-1:0]        hold_ms;
		logic [RATE_SCALED_W-1:0] rate_scaled; // decay_rate * DIV1000_RECIP
	} cfg_t;

endpackage

// ===== sv/lmphs_cfg_regs.sv =====
`timescale 1ns / 1ps
module lmphs_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [lmphs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lmphs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output lmphs_pkg::cfg_t                      cfg
);

	lmphs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atten_on    <= 1'b0;
			cfg_q.preamp_on   <= 1'b0;
			cfg_q.floor_db    <= lmphs_pkg::RST_FLOOR;
			cfg_q.ceiling_db  <= lmphs_pkg::RST_CEIL;
			cfg_q.hold_ms     <= lmphs_pkg::RST_HOLD;
			cfg_q.rate_scaled <= lmphs_pkg::RATE_SCALED_W'(lmphs_pkg::RST_RATE)
				* lmphs_pkg::RATE_SCALED_W'(lmphs_pkg::DIV1000_RECIP);
		end else if (cfg_valid) begin
			case (lmphs_pkg::cfg_reg_t'(cfg_index))
				lmphs_pkg::REG_ATTEN:  cfg_q.atten_on   <= cfg_data[0];
				lmphs_pkg::REG_PREAMP: cfg_q.preamp_on  <= cfg_data[0];
				lmphs_pkg::REG_FLOOR:  cfg_q.floor_db   <= $signed(cfg_data[lmphs_pkg::DB_W-1:0]);
				lmphs_pkg::REG_CEIL:   cfg_q.ceiling_db <= $signed(cfg_data[lmphs_pkg::DB_W-1:0]);
				lmphs_pkg::REG_HOLD:   cfg_q.hold_ms    <= cfg_data[lmphs_pkg::HOLD_W-1:0];
				lmphs_pkg::REG_RATE: begin
					// pre-scale so the per-item decay needs one multiply
					cfg_q.rate_scaled <=
						lmphs_pkg::RATE_SCALED_W'(cfg_data[lmphs_pkg::RATE_W-1:0])
						* lmphs_pkg::RATE_SCALED_W'(lmphs_pkg::DIV1000_RECIP);
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/lmphs_clamp.sv =====
`timescale 1ns / 1ps
module lmphs_clamp (
	input  lmphs_pkg::cfg_t                         cfg,
	input  logic signed [lmphs_pkg::LEVEL_W-1:0]    level_db,
	output logic signed [lmphs_pkg::LEVEL_W-1:0]    clamped_db
);

	logic signed [17:0] off_lvl;
	logic signed [17:0] flo_q8;
	logic signed [17:0] cei_q8;

	always_comb begin
		off_lvl = $signed({level_db[16], level_db});
		if (cfg.atten_on) begin
			off_lvl = off_lvl + lmphs_pkg::OFFSET_Q8;
		end
		if (cfg.preamp_on) begin
			off_lvl = off_lvl - lmphs_pkg::OFFSET_Q8;
		end
		flo_q8 = $signed({cfg.floor_db[8], cfg.floor_db, 8'b0});
		cei_q8 = $signed({cfg.ceiling_db[8], cfg.ceiling_db, 8'b0});
		// floor wins when floor sits above ceiling
		if (off_lvl < flo_q8) begin
			clamped_db = flo_q8[16:0];
		end else if (off_lvl > cei_q8) begin
			clamped_db = cei_q8[16:0];
		end else begin
			clamped_db = off_lvl[16:0];
		end
	end

endmodule

// ===== sv/lmphs_track.sv =====
`timescale 1ns / 1ps
module lmphs_track (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    update,
	input  lmphs_pkg::cfg_t                         cfg,
	input  logic signed [lmphs_pkg::LEVEL_W-1:0]    level_db,
	input  logic [lmphs_pkg::STAMP_W-1:0]           timestamp_ms,
	input  logic [lmphs_pkg::COEF_W-1:0]            smooth_coef,
	output logic signed [lmphs_pkg::DB_W-1:0]       smoothed_db,
	output logic signed [lmphs_pkg::DB_W-1:0]       peak_db
);

	logic signed [8:0]  smooth_q;
	logic signed [8:0]  peak_q;
	logic [31:0]        stamp_q;

	logic               is_new;
	logic signed [16:0] lvl_rnd;
	logic [31:0]        elapsed;
	logic               overdue;
	logic [31:0]        over_ms;
	logic [48:0]        dec_prod;
	logic [19:0]        dec;
	logic               dec_big;
	logic signed [10:0] np;
	logic signed [10:0] flo_ext;
	logic signed [8:0]  decayed;
	logic signed [8:0]  peak_d;
	logic [31:0]        stamp_d;
	logic signed [18:0] sm_diff;
	logic signed [35:0] sm_prod;
	logic signed [36:0] acc;
	logic signed [36:0] acc_rnd;

	always_comb begin
		is_new  = level_db > $signed({peak_q, 8'b0});
		// divide by 256 toward zero
		lvl_rnd = level_db + (level_db[16] ? 17'sd255 : 17'sd0);

		elapsed = timestamp_ms - stamp_q;
		overdue = elapsed > {16'b0, cfg.hold_ms};
		over_ms = elapsed - {16'b0, cfg.hold_ms};

		// decay of 512 dB or more always lands on the floor
		dec_prod = {30'b0, over_ms[18:0]} * {19'b0, cfg.rate_scaled};
		dec      = dec_prod[48:lmphs_pkg::DIV1000_SHIFT];
		dec_big  = ((|over_ms[31:19]) && (cfg.rate_scaled != '0)) || (|dec[19:9]);
		np       = $signed({peak_q[8], peak_q[8], peak_q}) - $signed({2'b0, dec[8:0]});
		flo_ext  = $signed({cfg.floor_db[8], cfg.floor_db[8], cfg.floor_db});
		if (dec_big || (np < flo_ext)) begin
			decayed = cfg.floor_db;
		end else begin
			decayed = np[8:0];
		end

		if (is_new) begin
			peak_d  = lvl_rnd[16:8];
			stamp_d = timestamp_ms;
		end else begin
			peak_d  = overdue ? decayed : peak_q;
			stamp_d = stamp_q;
		end

		// acc = lvl*2^16 + coef*(smooth*256 - lvl), units of 2^-24 dB
		sm_diff = $signed({smooth_q[8], smooth_q[8], smooth_q, 8'b0})
			- $signed({level_db[16], level_db[16], level_db});
		sm_prod = $signed({1'b0, smooth_coef}) * sm_diff;
		acc     = $signed({{4{level_db[16]}}, level_db, 16'b0}) + $signed({sm_prod[35], sm_prod});
		acc_rnd = acc + (acc[36] ? 37'sd16777215 : 37'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= lmphs_pkg::RST_FLOOR;
			peak_q   <= lmphs_pkg::RST_FLOOR;
			stamp_q  <= '0;
		end else if (update) begin
			smooth_q <= acc_rnd[32:24];
			peak_q   <= peak_d;
			stamp_q  <= stamp_d;
		end
	end

	assign smoothed_db = acc_rnd[32:24];
	assign peak_db     = peak_d;

endmodule

// ===== sv/level_meter_peak_hold_smoother.sv =====
`timescale 1ns / 1ps
// Pipeline: an input transfer is registered in the input stage, then in the result stage.
// Throughput: 1 item per cycle unless m_tready stalls the result stage; peak, stamp and
// smoothed level close their loop in the result stage (one 19x30 and one 17x19 multiply).
// Reset (arst_n low, async): config returns to defaults, peak and smoothed level
// to -121 dB, peak stamp to 0, both pipeline stages empty.
module level_meter_peak_hold_smoother (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [lmphs_pkg::S_TDATA_W-1:0]      s_tdata,  // level_db[16:0], timestamp_ms[48:17],
	                                                       // smooth_coef[64:49], zero[71:65]
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [lmphs_pkg::M_TDATA_W-1:0]      m_tdata,  // smoothed_db[8:0], peak_db[17:9],
	                                                       // clamped_db[34:18], zero[39:35]
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lmphs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lmphs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	lmphs_pkg::cfg_t cfg;

	logic               out_ready;
	logic               advance;
	logic               in_xfer;
	logic signed [16:0] clamped;

	// stage 1: offset and clamped level, raw stamp and coefficient
	logic               valid_s1;
	logic signed [16:0] level_s1;
	logic [31:0]        stamp_s1;
	logic [15:0]        coef_s1;

	// stage 2: result register feeding m_tdata
	logic               valid_s2;
	logic signed [8:0]  smoothed_s2;
	logic signed [8:0]  peak_s2;
	logic signed [16:0] clamped_s2;

	logic signed [8:0]  smoothed_nxt;
	logic signed [8:0]  peak_nxt;

	// registers are always writable; software must write only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	lmphs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lmphs_clamp u_clamp (
		.cfg        (cfg),
		.level_db   ($signed(s_tdata[16:0])),
		.clamped_db (clamped)
	);

	// result stage takes a new item when empty or when its item leaves this cycle
	assign out_ready = !valid_s2 || m_tready;
	assign advance   = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;
	assign in_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			level_s1 <= clamped;
			stamp_s1 <= s_tdata[48:17];
			coef_s1  <= s_tdata[64:49];
		end
	end

	// state moves forward exactly once per item, as it enters the result stage
	lmphs_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (advance),
		.cfg          (cfg),
		.level_db     (level_s1),
		.timestamp_ms (stamp_s1),
		.smooth_coef  (coef_s1),
		.smoothed_db  (smoothed_nxt),
		.peak_db      (peak_nxt)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			smoothed_s2 <= smoothed_nxt;
			peak_s2     <= peak_nxt;
			clamped_s2  <= level_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, clamped_s2, peak_s2, smoothed_s2};

endmodule

// ===== sv/lmphs_checker.sv =====
`timescale 1ns / 1ps
`include "level_meter_peak_hold_smoother_defines.svh"
module lmphs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lmphs_pkg::M_TDATA_W-1:0]   m_tdata
);

	// a stalled result holds its value
	`LMPHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a free result stage always lets the input side move
	`LMPHS_ASSERT_NOW(a_in_ready, !m_tvalid || m_tready, s_tready)

	// with the sink ready, a transferred item passes the input stage and then comes out valid
	`LMPHS_ASSERT_NEXT(a_latency, (s_tvalid && s_tready && m_tready) ##1 m_tready, m_tvalid)

endmodule

bind level_meter_peak_hold_smoother lmphs_checker u_lmphs_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_LEN   = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int IDLE_PCT       = 15;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 195;
	localparam int N_PHASES       = 8;

	localparam int LEVEL_MIN = -65536;
	localparam int LEVEL_MAX = 65535;
	localparam int DB_LO     = -160;
	localparam int DB_HI     = 40;
	localparam int Q8        = 256;
	localparam longint LSB_PER_DB     = 256;
	localparam longint OFFSET_14DB_Q8 = 14 * 256;
	localparam longint MS_PER_S       = 1000;
	localparam longint SMOOTH_ONE     = 65536;
	localparam longint SMOOTH_SCALE   = longint'(1) << 24;

	localparam int DEF_FLOOR = -121;
	localparam int DEF_CEIL  = -33;
	localparam int DEF_HOLD  = 1500;
	localparam int DEF_RATE  = 20;

	typedef logic signed [lmphs_pkg::LEVEL_W-1:0] level_t;
	typedef logic [lmphs_pkg::STAMP_W-1:0]        stamp_t;
	typedef logic [lmphs_pkg::COEF_W-1:0]         coef_t;
	typedef logic signed [lmphs_pkg::DB_W-1:0]    db_t;
	typedef logic [lmphs_pkg::HOLD_W-1:0]         hold_t;
	typedef logic [lmphs_pkg::RATE_W-1:0]         rate_t;
	typedef logic [lmphs_pkg::CFG_INDEX_W-1:0]    cfg_idx_t;
	typedef logic [lmphs_pkg::CFG_DATA_W-1:0]     cfg_word_t;

	// indexes the block does not decode; writes there must change nothing
	localparam cfg_idx_t REG_SPARE_LO = 3'd6;
	localparam cfg_idx_t REG_SPARE_HI = 3'd7;

	// one meter update, laid out as m_tdata[34:0]
	typedef struct packed {
		logic signed [lmphs_pkg::LEVEL_W-1:0] clamped;
		logic signed [lmphs_pkg::DB_W-1:0]    peak;
		logic signed [lmphs_pkg::DB_W-1:0]    smoothed;
	} meter_out_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic [lmphs_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
	logic                              m_tready  = 1'b0;
	logic                              cfg_valid = 1'b0;
	cfg_idx_t                          cfg_index = '0;
	cfg_word_t                         cfg_data  = '0;
	logic                              s_tready;
	logic                              m_tvalid;
	logic [lmphs_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                              cfg_ready;

	level_meter_peak_hold_smoother u_top (.*);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predicted meter state and register copy
	// ---------------------------------------------------------------
	logic   cfg_atten, cfg_preamp;
	db_t    cfg_floor, cfg_ceil;
	hold_t  cfg_hold;
	rate_t  cfg_rate;
	longint smooth_db, held_peak_db;
	stamp_t peak_stamp;

	meter_out_t meter_results_q[$];
	int         n_mismatch = 0;
	int         idle_run   = 0;
	bit         no_idle    = 1'b0;
	stamp_t     now_ms     = '0;

	// receiver hold-off bookkeeping: test side bumps hold_reqs, receiver does the rest
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;

	// Offset, clamp, peak hold/decay and smoothing for one accepted transfer.
	function automatic meter_out_t predict_meter(input level_t level, input stamp_t now,
			input coef_t coef);
		longint          lvl, flo, cei, acc, np, beta;
		longint unsigned elapsed, dec, hold, rate;
		stamp_t          since;
		meter_out_t      r;
		lvl  = longint'(level);
		flo  = longint'(cfg_floor);
		cei  = longint'(cfg_ceil);
		beta = longint'(coef);
		hold = 64'(cfg_hold);
		rate = 64'(cfg_rate);
		if (cfg_atten)
			lvl += OFFSET_14DB_Q8;
		if (cfg_preamp)
			lvl -= OFFSET_14DB_Q8;
		// floor wins over ceiling when the two are crossed
		if (lvl < flo * LSB_PER_DB)
			lvl = flo * LSB_PER_DB;
		else if (lvl > cei * LSB_PER_DB)
			lvl = cei * LSB_PER_DB;

		if (lvl > held_peak_db * LSB_PER_DB) begin
			held_peak_db = lvl / LSB_PER_DB;
			peak_stamp   = now;
		end else begin
			since   = now - peak_stamp;   // wraps mod 2^32
			elapsed = {32'b0, since};
			if (elapsed > hold) begin
				// overdue time is not re-armed, so the drop grows each update
				dec = (elapsed - hold) * rate / MS_PER_S;
				np  = held_peak_db - longint'(dec);
				if (np < flo)
					np = flo;
				held_peak_db = np;
			end
		end

		acc       = smooth_db * LSB_PER_DB * beta + lvl * (SMOOTH_ONE - beta);
		smooth_db = acc / SMOOTH_SCALE;

		r.smoothed = smooth_db[lmphs_pkg::DB_W-1:0];
		r.peak     = held_peak_db[lmphs_pkg::DB_W-1:0];
		r.clamped  = lvl[lmphs_pkg::LEVEL_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic send_level(input level_t level, input stamp_t stamp, input coef_t coef);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(lmphs_pkg::S_TDATA_W - lmphs_pkg::LEVEL_W - lmphs_pkg::STAMP_W
			- lmphs_pkg::COEF_W){1'b0}}, coef, stamp, level};
		do @(posedge clk); while (!s_tready);
		meter_results_q.push_back(predict_meter(level, stamp, coef));
	endtask

	// advance the meter clock by dt ms, then send
	task automatic send_at(input int level, input int unsigned dt);
		now_ms += dt;
		send_level(level_t'(level), now_ms, coef_t'($urandom));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (meter_results_q.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after its last write
	task automatic write_reg(input cfg_idx_t idx, input cfg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lmphs_pkg::REG_ATTEN:  cfg_atten  = data[0];
			lmphs_pkg::REG_PREAMP: cfg_preamp = data[0];
			lmphs_pkg::REG_FLOOR:  cfg_floor  = data[lmphs_pkg::DB_W-1:0];
			lmphs_pkg::REG_CEIL:   cfg_ceil   = data[lmphs_pkg::DB_W-1:0];
			lmphs_pkg::REG_HOLD:   cfg_hold   = data[lmphs_pkg::HOLD_W-1:0];
			lmphs_pkg::REG_RATE:   cfg_rate   = data[lmphs_pkg::RATE_W-1:0];
			default: ;
		endcase
	endtask

	// Full register set; unused upper data bits carry junk that must be masked.
	task automatic configure(input bit atten, input bit preamp, input int floor_db,
			input int ceil_db, input int hold, input int rate);
		cfg_word_t pad;
		db_t       f9, c9;
		rate_t     r10;
		pad = cfg_word_t'($urandom);
		f9  = db_t'(floor_db);
		c9  = db_t'(ceil_db);
		r10 = rate_t'(rate);
		wait_results_drained();
		write_reg(lmphs_pkg::REG_ATTEN,  {pad[lmphs_pkg::CFG_DATA_W-1:1], atten});
		write_reg(lmphs_pkg::REG_PREAMP, {~pad[lmphs_pkg::CFG_DATA_W-1:1], preamp});
		write_reg(lmphs_pkg::REG_FLOOR,  {pad[lmphs_pkg::CFG_DATA_W-1:lmphs_pkg::DB_W], f9});
		write_reg(lmphs_pkg::REG_CEIL,   {~pad[lmphs_pkg::CFG_DATA_W-1:lmphs_pkg::DB_W], c9});
		write_reg(lmphs_pkg::REG_HOLD,   cfg_word_t'(hold));
		write_reg(lmphs_pkg::REG_RATE,   {pad[lmphs_pkg::CFG_DATA_W-1:lmphs_pkg::RATE_W], r10});
		cfg_valid <= 1'b0;
	endtask

	// Mostly a live meter feed: small time steps and levels around the display
	// window, with some raw full-range levels and long or wrapping time jumps.
	task automatic send_random_item();
		int unsigned pick, dt;
		int          lvl, lo, hi, f, c;
		level_t      raw;
		coef_t       coef;
		f    = int'(cfg_floor);
		c    = int'(cfg_ceil);
		lo   = ((f < c) ? f : c) - 10;
		hi   = ((f < c) ? c : f) + 5;
		pick = $urandom_range(99);
		if (pick < 70)
			dt = $urandom_range(300);
		else if (pick < 92)
			dt = $urandom_range(5000, 300);
		else
			dt = $urandom;
		now_ms += dt;
		pick = $urandom_range(99);
		raw  = level_t'($urandom);
		if (pick < 15)
			lvl = int'(raw);
		else if (pick < 30)
			lvl = c * Q8 - 3 * Q8 + int'($urandom_range(6 * Q8));
		else
			lvl = lo * Q8 + int'($urandom_range((hi - lo) * Q8));
		pick = $urandom_range(99);
		if (pick < 10)
			coef = '0;
		else if (pick < 20)
			coef = '1;
		else
			coef = coef_t'($urandom);
		send_level(level_t'(lvl), now_ms, coef);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// reset registers: raw field extremes and a level right on the floor
	task automatic test_field_extremes();
		send_level(level_t'(LEVEL_MIN), '0, '0);
		send_level(level_t'(LEVEL_MAX), 32'd1, '1);
		send_level('0, '1, 16'h8000);
		send_level(level_t'(DEF_FLOOR * Q8), 32'd1000, coef_t'($urandom));
		now_ms = 32'd1000;
	endtask

	task automatic test_offsets();
		configure(1'b1, 1'b0, DEF_FLOOR, DEF_CEIL, DEF_HOLD, DEF_RATE);
		send_at(-35 * Q8, 10);         // lifted past the ceiling
		send_at(-134 * Q8 + 77, 10);   // lifted just over the floor
		configure(1'b0, 1'b1, DEF_FLOOR, DEF_CEIL, DEF_HOLD, DEF_RATE);
		send_at(-20 * Q8, 10);
		send_at(-110 * Q8 - 5, 10);    // dropped under the floor
		configure(1'b1, 1'b1, DEF_FLOOR, DEF_CEIL, DEF_HOLD, DEF_RATE);
		send_at(-40 * Q8 + 13, 10);    // offsets cancel
		send_at(-30 * Q8, 10);
	endtask

	// floor 0 dB over ceiling -50 dB: below floor -> floor, anything else -> ceiling
	task automatic test_crossed_limits();
		configure(1'b0, 1'b0, 0, -50, DEF_HOLD, DEF_RATE);
		send_at(-60 * Q8, 5);
		send_at(10 * Q8, 5);
		send_at(-20 * Q8, 5);
	endtask

	task automatic test_peak_hold_decay();
		configure(1'b0, 1'b0, DB_LO, DB_HI, 100, 1023);
		now_ms = 32'd1000;
		send_at(30 * Q8, 0);       // new peak
		send_at(-100 * Q8, 50);    // inside hold
		send_at(-100 * Q8, 51);    // just past hold, one dB down
		send_at(-100 * Q8, 99);    // decay keeps growing
		send_at(-100 * Q8, 3800);  // saturates at the floor
		now_ms = 32'hFFFF_FFC0;
		send_at(35 * Q8, 0);       // peak stamped just before the wrap
		send_at(-150 * Q8, 320);   // elapsed measured across the wrap
		send_at(-5000, 10);        // fractional negative peak truncates toward zero
	endtask

	// peak parked below a raised floor is lifted by the decay path
	task automatic test_floor_lifts_peak();
		configure(1'b0, 1'b0, DB_LO, DB_HI, 0, 1023);
		send_at(-150 * Q8, 100000);
		configure(1'b0, 1'b0, 20, DB_LO, 0, 0);
		send_at(30 * Q8, 5);
	endtask

	task automatic test_spare_index();
		wait_results_drained();
		write_reg(REG_SPARE_LO, cfg_word_t'($urandom));
		write_reg(REG_SPARE_HI, '1);
		cfg_valid <= 1'b0;
		send_at(-50 * Q8, 20);
	endtask

	// receiver stalls long enough for the pipe to fill and push back on the input
	task automatic test_backpressure();
		configure(1'b0, 1'b0, DEF_FLOOR, DEF_CEIL, DEF_HOLD, DEF_RATE);
		hold_reqs = hold_reqs + 1;
		repeat (40)
			send_random_item();
	endtask

	task automatic test_random_phases();
		int f, c, t;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: configure(1'b0, 1'b0, DB_LO, DB_HI, 0, 1023);
				1: configure(1'b1, 1'b1, DB_HI, DB_HI, 65535, 0);
				2: configure(1'b0, 1'b1, DB_LO, DB_LO, 1, 1);
				default: begin
					f = DB_LO + int'($urandom_range(DB_HI - DB_LO));
					c = DB_LO + int'($urandom_range(DB_HI - DB_LO));
					// keep the window sane most of the time
					if (f > c && $urandom_range(99) < 80) begin
						t = f;
						f = c;
						c = t;
					end
					configure(1'($urandom_range(1)), 1'($urandom_range(1)), f, c,
						$urandom_range(99) < 20 ? int'($urandom_range(65535))
						: int'($urandom_range(3000)),
						int'($urandom_range(1023)));
				end
			endcase
			if (ph == 5)
				now_ms = 32'hFFFF_F000;
			no_idle = (ph == 3);
			repeat (PHASE_ITEMS)
				send_random_item();
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Receiver: random stalls, plus long hold-offs on request
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_reqs) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_OFF_LEN - 1;
			hold_done <= hold_done + 1;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic note_mismatch(input string what, input longint want, input longint got);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("%t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Result checker: every output transfer against the oldest prediction.
	always @(posedge clk) begin : check_results
		meter_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = meter_out_t'(m_tdata[$bits(meter_out_t)-1:0]);
			if (meter_results_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS)
					$display("%t: result transfer with nothing pending, m_tdata %h",
						$realtime, m_tdata);
			end else begin
				want = meter_results_q.pop_front();
				if (got.smoothed !== want.smoothed)
					note_mismatch("smoothed_db", longint'(want.smoothed),
						longint'(got.smoothed));
				if (got.peak !== want.peak)
					note_mismatch("peak_db", longint'(want.peak), longint'(got.peak));
				if (got.clamped !== want.clamped)
					note_mismatch("clamped_db", longint'(want.clamped),
						longint'(got.clamped));
			end
		end
	end

	// Watchdog: too long without any transfer on any channel means a hang.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_run <= 0;
		else if (idle_run == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			idle_run <= idle_run + 1;
	end

	initial begin
		// predicted state at reset
		cfg_atten    = 1'b0;
		cfg_preamp   = 1'b0;
		cfg_floor    = db_t'(DEF_FLOOR);
		cfg_ceil     = db_t'(DEF_CEIL);
		cfg_hold     = hold_t'(DEF_HOLD);
		cfg_rate     = rate_t'(DEF_RATE);
		smooth_db    = longint'(DEF_FLOOR);
		held_peak_db = longint'(DEF_FLOOR);
		peak_stamp   = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_offsets();
		test_crossed_limits();
		test_peak_hold_decay();
		test_floor_lifts_peak();
		test_spare_index();
		test_backpressure();
		test_random_phases();

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_mismatch == 0 && meter_results_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
